// ===== hw/rtl/hrlf_pkg.sv =====
// Shared constants, payload types and the length-prefix table for the
// HTTP response length framer. No dependencies.
package hrlf_pkg;

  localparam int LENGTH_BITS = 31;
  localparam int PREFIX_LEN  = 16;
  localparam int LINE_POS_W  = 5;
  localparam int SUM_W       = LENGTH_BITS + 4;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef logic [LENGTH_BITS-1:0] length_t;
  typedef logic [LINE_POS_W-1:0]  line_pos_t;

  typedef struct packed {
    logic       is_body;
    logic [7:0] body_byte;
    logic       last_body;
    logic       reply_done;
    logic       header_complete;
    logic       length_known;
  } result_t;

  // Characters of "Content-Length: " by position in the line.
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/hrlf_if.sv =====
// Valid/ready channel interfaces for the framer: response bytes in, results out.
// No dependencies.
interface hrlf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface hrlf_result_if;
  logic       valid;
  logic       ready;
  logic       is_body;
  logic [7:0] body_byte;
  logic       last_body;
  logic       reply_done;
  logic       header_complete;
  logic       length_known;

  modport source (output valid, output is_body, output body_byte, output last_body,
                  output reply_done, output header_complete, output length_known,
                  input ready);
  modport sink   (input valid, input is_body, input body_byte, input last_body,
                  input reply_done, input header_complete, input length_known,
                  output ready);
endinterface

// ===== hw/rtl/http_response_length_framer.sv =====
// Each accepted byte's result is registered in the output or the skid register.
// Throughput: one byte per cycle; a two-entry output buffer (result register plus skid
// register) lets a byte be taken while one result waits, and stalls input only when both
// are full. Reset (rst, synchronous) clears parser state and both output slots; no
// clearing pass is needed.
// Depends on hrlf_pkg and hrlf_if.
module http_response_length_framer (
  input  logic          clk,
  input  logic          rst,
  hrlf_byte_if.sink     byte_ch,
  hrlf_result_if.source result_ch
);

  hrlf_pkg::line_pos_t line_position, line_position_next;
  logic                prefix_matching, prefix_matching_next;
  logic                first_was_cr, first_was_cr_next;
  hrlf_pkg::length_t   digit_value, digit_value_next;
  logic                value_invalid, value_invalid_next;
  logic                cr_pending, cr_pending_next;
  logic                have_length, have_length_next;
  hrlf_pkg::length_t   body_length, body_length_next;
  logic                header_ended, header_ended_next;
  hrlf_pkg::length_t   body_count, body_count_next;
  logic                reply_finished, reply_finished_next;

  hrlf_pkg::result_t   result_next;
  hrlf_pkg::result_t   out_data, skid_data;
  logic                out_valid, skid_valid;
  logic                accept, pop;

  assign byte_ch.ready = !skid_valid;
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign pop           = out_valid && result_ch.ready;

  always_comb begin
    logic [7:0]                  b;
    logic [3:0]                  digit;
    logic [hrlf_pkg::SUM_W-1:0]  dv_ext;
    logic [hrlf_pkg::SUM_W-1:0]  sum;
    logic                        is_body, last, done;

    b      = byte_ch.data_byte;
    digit  = b[3:0];
    is_body = 1'b0;
    last    = 1'b0;
    done    = 1'b0;

    line_position_next   = line_position;
    prefix_matching_next = prefix_matching;
    first_was_cr_next    = first_was_cr;
    digit_value_next     = digit_value;
    value_invalid_next   = value_invalid;
    cr_pending_next      = cr_pending;
    have_length_next     = have_length;
    body_length_next     = body_length;
    header_ended_next    = header_ended;
    body_count_next      = body_count;
    reply_finished_next  = reply_finished;

    if (byte_ch.restart) begin
      line_position_next   = '0;
      prefix_matching_next = 1'b1;
      first_was_cr_next    = 1'b0;
      digit_value_next     = '0;
      value_invalid_next   = 1'b0;
      cr_pending_next      = 1'b0;
      have_length_next     = 1'b0;
      body_length_next     = '0;
      header_ended_next    = 1'b0;
      body_count_next      = '0;
      reply_finished_next  = 1'b0;
    end

    dv_ext = {4'b0, digit_value_next};
    sum    = (dv_ext << 3) + (dv_ext << 1) + {{(hrlf_pkg::SUM_W-4){1'b0}}, digit};

    if (!header_ended_next) begin
      if (b == hrlf_pkg::CHAR_LF) begin
        if (line_position_next == '0 ||
            (line_position_next == hrlf_pkg::LINE_POS_W'(1) && first_was_cr_next)) begin
          header_ended_next = 1'b1;
          // zero-length body completes on the blank line itself
          if (have_length_next && body_length_next == '0 && !reply_finished_next) begin
            reply_finished_next = 1'b1;
            done                = 1'b1;
          end
        end else if (prefix_matching_next &&
                     line_position_next >= hrlf_pkg::LINE_POS_W'(hrlf_pkg::PREFIX_LEN)) begin
          have_length_next = 1'b1;
          body_length_next = value_invalid_next ? '0 : digit_value_next;
        end
        line_position_next   = '0;
        prefix_matching_next = 1'b1;
        first_was_cr_next    = 1'b0;
        digit_value_next     = '0;
        value_invalid_next   = 1'b0;
        cr_pending_next      = 1'b0;
      end else begin
        if (line_position_next == '0 && b == hrlf_pkg::CHAR_CR)
          first_was_cr_next = 1'b1;
        if (line_position_next < hrlf_pkg::LINE_POS_W'(hrlf_pkg::PREFIX_LEN)) begin
          if (b != hrlf_pkg::prefix_char(line_position_next[3:0]))
            prefix_matching_next = 1'b0;
          line_position_next = line_position_next + hrlf_pkg::LINE_POS_W'(1);
        end else if (prefix_matching_next) begin
          // a CR followed by anything but LF spoils the value
          if (cr_pending_next)
            value_invalid_next = 1'b1;
          cr_pending_next = 1'b0;
          if (b == hrlf_pkg::CHAR_CR) begin
            cr_pending_next = 1'b1;
          end else if (b >= hrlf_pkg::CHAR_ZERO && b <= hrlf_pkg::CHAR_NINE) begin
            if (!value_invalid_next) begin
              if (sum[hrlf_pkg::SUM_W-1:hrlf_pkg::LENGTH_BITS] != '0)
                value_invalid_next = 1'b1;
              else
                digit_value_next = sum[hrlf_pkg::LENGTH_BITS-1:0];
            end
          end else begin
            value_invalid_next = 1'b1;
          end
        end
      end
    end else if (have_length_next && body_count_next < body_length_next) begin
      is_body         = 1'b1;
      body_count_next = body_count_next + hrlf_pkg::LENGTH_BITS'(1);
      if (body_count_next == body_length_next) begin
        last = 1'b1;
        if (!reply_finished_next) begin
          reply_finished_next = 1'b1;
          done                = 1'b1;
        end
      end
    end

    result_next.is_body         = is_body;
    result_next.body_byte       = is_body ? b : 8'h00;
    result_next.last_body       = last;
    result_next.reply_done      = done;
    result_next.header_complete = header_ended_next;
    result_next.length_known    = have_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position   <= '0;
      prefix_matching <= 1'b1;
      first_was_cr    <= 1'b0;
      digit_value     <= '0;
      value_invalid   <= 1'b0;
      cr_pending      <= 1'b0;
      have_length     <= 1'b0;
      body_length     <= '0;
      header_ended    <= 1'b0;
      body_count      <= '0;
      reply_finished  <= 1'b0;
    end else if (accept) begin
      line_position   <= line_position_next;
      prefix_matching <= prefix_matching_next;
      first_was_cr    <= first_was_cr_next;
      digit_value     <= digit_value_next;
      value_invalid   <= value_invalid_next;
      cr_pending      <= cr_pending_next;
      have_length     <= have_length_next;
      body_length     <= body_length_next;
      header_ended    <= header_ended_next;
      body_count      <= body_count_next;
      reply_finished  <= reply_finished_next;
    end
  end

  // Output register with skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data <= result_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_data  <= result_next;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign result_ch.valid           = out_valid;
  assign result_ch.is_body         = out_data.is_body;
  assign result_ch.body_byte       = out_data.body_byte;
  assign result_ch.last_body       = out_data.last_body;
  assign result_ch.reply_done      = out_data.reply_done;
  assign result_ch.header_complete = out_data.header_complete;
  assign result_ch.length_known    = out_data.length_known;

endmodule

// ===== bench/tb_http_response_length_framer.sv =====
// Testbench for http_response_length_framer: drives response bytes with random gaps
// and backpressure, predicts each result and checks it in order.
// Depends on hrlf_pkg, hrlf_if and the framer RTL.
module tb_http_response_length_framer;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_BYTES  = 350;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [8*hrlf_pkg::PREFIX_LEN-1:0] LENGTH_PREFIX = "Content-Length: ";

  class framer_scoreboard;
    hrlf_pkg::result_t expected_results[$];
    int errors;
    int line_pos;
    bit prefix_ok, first_cr, val_bad, cr_seen, len_known, hdr_ended, finished;
    longint unsigned value;
    longint unsigned body_len, body_cnt;

    function new();
      errors = 0;
      clear_all();
    endfunction

    function void new_line();
      line_pos  = 0;
      prefix_ok = 1;
      first_cr  = 0;
      value     = 0;
      val_bad   = 0;
      cr_seen   = 0;
    endfunction

    function void clear_all();
      new_line();
      len_known = 0;
      body_len  = 0;
      hdr_ended = 0;
      body_cnt  = 0;
      finished  = 0;
    endfunction

    function void take_value_char(logic [7:0] b);
      longint unsigned d, max_len;
      max_len = (64'd1 << hrlf_pkg::LENGTH_BITS) - 1;
      // a CR followed by anything but LF spoils the value
      if (cr_seen) val_bad = 1;
      cr_seen = 0;
      if (b == hrlf_pkg::CHAR_CR) begin
        cr_seen = 1;
      end else if (b >= hrlf_pkg::CHAR_ZERO && b <= hrlf_pkg::CHAR_NINE) begin
        d = 64'(b - hrlf_pkg::CHAR_ZERO);
        if (!val_bad) begin
          if (value > (max_len - d) / 10) val_bad = 1;
          else value = value * 10 + d;
        end
      end else begin
        val_bad = 1;
      end
    endfunction

    // Predict the result of one accepted request.
    function void note_request(logic [7:0] b, logic rs);
      hrlf_pkg::result_t want;
      want = '0;
      if (rs) clear_all();
      if (!hdr_ended) begin
        if (b == hrlf_pkg::CHAR_LF) begin
          if (line_pos == 0 || (line_pos == 1 && first_cr)) begin
            hdr_ended = 1;
            if (len_known && body_len == 0 && !finished) begin
              finished = 1;
              want.reply_done = 1;
            end
          end else if (prefix_ok && line_pos >= hrlf_pkg::PREFIX_LEN) begin
            len_known = 1;
            body_len  = val_bad ? 0 : value;
          end
          new_line();
        end else begin
          if (line_pos == 0 && b == hrlf_pkg::CHAR_CR) first_cr = 1;
          if (line_pos < hrlf_pkg::PREFIX_LEN) begin
            if (b != LENGTH_PREFIX[8*(hrlf_pkg::PREFIX_LEN-1-line_pos) +: 8]) prefix_ok = 0;
            line_pos++;
          end else if (prefix_ok) begin
            take_value_char(b);
          end
        end
      end else if (len_known && body_cnt < body_len) begin
        want.is_body   = 1;
        want.body_byte = b;
        body_cnt++;
        if (body_cnt == body_len) begin
          want.last_body = 1;
          if (!finished) begin
            finished = 1;
            want.reply_done = 1;
          end
        end
      end
      want.header_complete = hdr_ended;
      want.length_known    = len_known;
      expected_results.push_back(want);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(hrlf_pkg::result_t got);
      hrlf_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      check_field("is_body", 8'(want.is_body), 8'(got.is_body));
      check_field("body_byte", want.body_byte, got.body_byte);
      check_field("last_body", 8'(want.last_body), 8'(got.last_body));
      check_field("reply_done", 8'(want.reply_done), 8'(got.reply_done));
      check_field("header_complete", 8'(want.header_complete), 8'(got.header_complete));
      check_field("length_known", 8'(want.length_known), 8'(got.length_known));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   bytes_sent = 0;
  framer_scoreboard board;

  hrlf_byte_if   byte_ch();
  hrlf_result_if result_ch();

  http_response_length_framer dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_http_response_length_framer: errors");
      $finish;
    end
  end

  // Result side: random backpressure, check every accepted result.
  always @(posedge clk) begin
    hrlf_pkg::result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.is_body         = result_ch.is_body;
      got.body_byte       = result_ch.body_byte;
      got.last_body       = result_ch.last_body;
      got.reply_done      = result_ch.reply_done;
      got.header_complete = result_ch.header_complete;
      got.length_known    = result_ch.length_known;
      board.check_result(got);
    end
    result_ch.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic push_byte(input logic [7:0] b, input logic rs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.restart   <= rs;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    board.note_request(b, rs);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // End a line with CR LF or a bare LF.
  task automatic send_eol();
    if ($urandom_range(0, 1)) push_byte(hrlf_pkg::CHAR_CR, 1'b0);
    push_byte(hrlf_pkg::CHAR_LF, 1'b0);
  endtask

  task automatic send_length_line(inout longint eff);
    int n;
    send_text("Content-Length: ");
    case ($urandom_range(0, 13))
      0, 1, 2, 3, 4, 5: begin
        n = $urandom_range(0, 24);
        if ($urandom_range(0, 3) == 0) send_text("00");
        send_text($sformatf("%0d", n));
        eff = longint'(n);
      end
      6: eff = 0;  // empty value
      7: begin
        case ($urandom_range(0, 5))
          0: send_text("+5");
          1: send_text("-1");
          2: send_text(" 7");
          3: send_text("7 ");
          4: send_text("3a");
          default: send_text("x");
        endcase
        eff = 0;
      end
      8: begin
        // stray CR inside the value
        send_text("1");
        push_byte(hrlf_pkg::CHAR_CR, 1'b0);
        send_text("2");
        eff = 0;
      end
      9: begin
        send_text("4");
        push_byte(hrlf_pkg::CHAR_CR, 1'b0);
        eff = 0;
      end
      10: begin
        send_text("2147483648");
        eff = 0;
      end
      11: begin
        send_text("99999999999");
        eff = 0;
      end
      12: begin
        send_text("2147483647");
        eff = 2147483647;
      end
      default: begin
        send_text("0");
        eff = 0;
      end
    endcase
    send_eol();
  endtask

  task automatic send_other_line();
    int n;
    logic [7:0] b;
    case ($urandom_range(0, 6))
      0: send_text("Host: a");
      1: send_text("C");
      2: send_text("Content-Length:5");
      3: send_text("content-length: 4");
      4: send_text("Content-Length");
      5: send_text("X-Long-Header-Name-Here: value");
      default: begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == hrlf_pkg::CHAR_LF) b = hrlf_pkg::CHAR_NINE;
          push_byte(b, 1'b0);
        end
      end
    endcase
    send_eol();
  endtask

  task automatic send_response();
    longint eff;
    int nbody;
    eff = -1;
    push_byte("H", $urandom_range(0, 99) < 85);
    send_text("TTP/1.1 200 OK");
    send_eol();
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 9) < 6) send_length_line(eff);
      else send_other_line();
    end
    send_eol();  // blank line ends the header
    if (eff >= 0 && eff <= 64) nbody = int'(eff) + int'($urandom_range(0, 2));
    else nbody = $urandom_range(0, 10);
    repeat (nbody) push_byte(8'($urandom_range(0, 255)), 1'b0);
    // header-like text after the end must not be parsed
    if ($urandom_range(0, 5) == 0) begin
      send_text("Content-Length: 9");
      send_eol();
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 24))
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    board = new();
    rst                 <= 1'b1;
    byte_ch.valid       <= 1'b0;
    byte_ch.data_byte   <= '0;
    byte_ch.restart     <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 85;
    // sized reply with CR LF endings, extreme body bytes
    push_byte("C", 1'b1);
    send_text("ontent-Length: 3");
    push_byte(hrlf_pkg::CHAR_CR, 1'b0);
    push_byte(hrlf_pkg::CHAR_LF, 1'b0);
    push_byte(hrlf_pkg::CHAR_CR, 1'b0);
    push_byte(hrlf_pkg::CHAR_LF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 34; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_response();
      end
    end
    byte_ch.valid <= 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("tb_http_response_length_framer: clean");
    else
      $display("tb_http_response_length_framer: errors");
    $finish;
  end

endmodule
